// File: hdl/bep_pkg.sv
// Shared types, constants and character tables for the byte escape printer.
// No dependencies; the encoder, serializer and top level refer to this package.
package bep_pkg;

  localparam int unsigned CapW = 16;
  localparam int unsigned CharW = 7;
  localparam int unsigned MaxSeq = 4;
  localparam int unsigned IdxW = $clog2(MaxSeq);
  localparam int unsigned LenW = $clog2(MaxSeq + 1);

  localparam logic [CapW-1:0] CAP_RESET = 16'd512;
  localparam logic [CapW-1:0] REQ_MAX = 16'hFFFF;
  localparam logic [CapW-1:0] REQ_START = 16'd1;

  localparam logic [CharW-1:0] CH_NUL = 7'h00;
  localparam logic [CharW-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CharW-1:0] CH_X = 7'h78;

  localparam logic [LenW-1:0] LEN_PLAIN = 3'd1;
  localparam logic [LenW-1:0] LEN_SHORT = 3'd2;
  localparam logic [LenW-1:0] LEN_HEX = 3'd4;

  // One rendered escape, handed from the encoder to the serializer
  typedef struct packed {
    logic [MaxSeq-1:0][CharW-1:0] chars;
    logic [IdxW-1:0] last_idx;
    logic char_valid;
    logic [CapW-1:0] required;
  } seq_t;

  // Letter after the backslash for tab .. carriage return (low nibble 9..D)
  function automatic logic [CharW-1:0] ctrl_letter(input logic [3:0] nib);
    logic [CharW-1:0] c;
    case (nib)
      4'h9: c = 7'h74;  // t
      4'hA: c = 7'h6E;  // n
      4'hB: c = 7'h76;  // v
      4'hC: c = 7'h66;  // f
      4'hD: c = 7'h72;  // r
      default: c = 7'h74;
    endcase
    return c;
  endfunction

  // Uppercase hex digit
  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'hA) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// File: hdl/bep_in_if.sv
// Input channel of the byte escape printer: one raw byte per beat.
// Depends on nothing but plain logic types.
interface bep_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic new_string;

  modport source (output valid, output data_byte, output new_string, input ready);
  modport sink (input valid, input data_byte, input new_string, output ready);
endinterface

// File: hdl/bep_out_if.sv
// Output channel of the byte escape printer: one character result per beat.
// Depends on nothing but plain logic types.
interface bep_out_if;
  logic valid;
  logic ready;
  logic [6:0] out_char;
  logic char_valid;
  logic last_of_run;
  logic [15:0] required_total;

  modport source (output valid, output out_char, output char_valid,
                  output last_of_run, output required_total, input ready);
  modport sink (input valid, input out_char, input char_valid,
                input last_of_run, input required_total, output ready);
endinterface

// File: hdl/bep_encoder.sv
// Encoder stage: classifies each input byte, tracks space and required length,
// and registers the rendered escape. Depends on bep_pkg and bep_in_if.
module bep_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bep_pkg::CapW-1:0]  cfg_wdata_i,
  bep_in_if.sink                    in_i,
  output bep_pkg::seq_t             seq_o,
  output logic                      seq_valid_o,
  input  logic                      seq_take_i
);

  logic [bep_pkg::CapW-1:0] cap_q;
  logic [bep_pkg::CapW-1:0] space_left_q, space_left_d;
  logic [bep_pkg::CapW-1:0] required_q, required_d;
  logic                     seq_valid_q;
  bep_pkg::seq_t            seq_q, seq_d;

  logic [bep_pkg::CapW-1:0] sl, rc;
  logic [bep_pkg::CapW:0]   sum;
  logic [bep_pkg::LenW-1:0] len;
  logic                     fits;
  logic                     accept;
  logic [7:0]               b;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !seq_valid_q || seq_take_i;

  // Render the byte and work out the counter updates
  always_comb begin
    b = in_i.data_byte;
    sl = in_i.new_string ? cap_q : space_left_q;
    rc = in_i.new_string ? bep_pkg::REQ_START : required_q;
    seq_d = '0;
    if (b inside {[8'h09:8'h0D]}) begin
      len = bep_pkg::LEN_SHORT;
      seq_d.chars[0] = bep_pkg::CH_BSLASH;
      seq_d.chars[1] = bep_pkg::ctrl_letter(b[3:0]);
    end else if (b == 8'h5C) begin
      len = bep_pkg::LEN_SHORT;
      seq_d.chars[0] = bep_pkg::CH_BSLASH;
      seq_d.chars[1] = bep_pkg::CH_BSLASH;
    end else if (b inside {[8'h20:8'h7E]}) begin
      len = bep_pkg::LEN_PLAIN;
      seq_d.chars[0] = b[6:0];
    end else begin
      len = bep_pkg::LEN_HEX;
      seq_d.chars[0] = bep_pkg::CH_BSLASH;
      seq_d.chars[1] = bep_pkg::CH_X;
      seq_d.chars[2] = bep_pkg::hex_digit(b[7:4]);
      seq_d.chars[3] = bep_pkg::hex_digit(b[3:0]);
    end

    // Saturating required length
    sum = {1'b0, rc} + {{(bep_pkg::CapW + 1 - bep_pkg::LenW){1'b0}}, len};
    required_d = sum[bep_pkg::CapW] ? bep_pkg::REQ_MAX : sum[bep_pkg::CapW-1:0];

    // Escape is written only if it leaves room for the terminator
    fits = sl > {{(bep_pkg::CapW - bep_pkg::LenW){1'b0}}, len};
    if (fits) begin
      space_left_d = sl - {{(bep_pkg::CapW - bep_pkg::LenW){1'b0}}, len};
      seq_d.last_idx = bep_pkg::IdxW'(len - 1'b1);
      seq_d.char_valid = 1'b1;
    end else begin
      space_left_d = sl;
      seq_d.chars = '0;
      seq_d.chars[0] = bep_pkg::CH_NUL;
      seq_d.last_idx = '0;
      seq_d.char_valid = 1'b0;
    end
    seq_d.required = required_d;
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bep_pkg::CAP_RESET;
      space_left_q <= bep_pkg::CAP_RESET;
      required_q <= bep_pkg::REQ_START;
      seq_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        space_left_q <= space_left_d;
        required_q <= required_d;
        seq_valid_q <= 1'b1;
      end else if (seq_take_i) begin
        seq_valid_q <= 1'b0;
      end
    end
  end

  // Rendered escape, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q <= seq_d;
    end
  end

  assign seq_o = seq_q;
  assign seq_valid_o = seq_valid_q;

  // A skipped escape leaves the space counter unchanged, or at the capacity on a restart
  a_skip_keeps_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !fits |=> space_left_q == $past(sl))
    else $error("space changed on skipped escape");

  // Required length never drops to zero
  a_required_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    required_q != '0)
    else $error("required length is zero");

endmodule

// File: hdl/bep_serializer.sv
// Serializer stage: steps through a rendered escape one character per cycle,
// while the output is not stalled, into the output register. Depends on bep_pkg and bep_out_if.
module bep_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bep_pkg::seq_t  seq_i,
  input  logic           seq_valid_i,
  output logic           seq_take_o,
  bep_out_if.source      out_o
);

  logic [bep_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                      out_valid_q;
  logic [bep_pkg::CharW-1:0] char_q;
  logic                      char_valid_q;
  logic                      last_q;
  logic [bep_pkg::CapW-1:0]  required_q;

  logic out_load;
  logic move;
  logic at_last;

  // Output register takes a beat when empty or being drained
  assign out_load = !out_valid_q || out_o.ready;
  assign move = seq_valid_i && out_load;
  assign at_last = idx_q == seq_i.last_idx;
  assign seq_take_o = move && at_last;
  assign idx_d = at_last ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (move) begin
        idx_q <= idx_d;
      end
      if (out_load) begin
        out_valid_q <= seq_valid_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      char_q <= seq_i.chars[idx_q];
      char_valid_q <= seq_i.char_valid;
      last_q <= at_last;
      required_q <= seq_i.required;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_char = char_q;
  assign out_o.char_valid = char_valid_q;
  assign out_o.last_of_run = last_q;
  assign out_o.required_total = required_q;

  // Index stays inside the escape being sent
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_i |-> idx_q <= seq_i.last_idx)
    else $error("character index past end of escape");

  // A skipped escape is a single closing beat
  a_skip_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !char_valid_q |-> last_q && char_q == bep_pkg::CH_NUL)
    else $error("skipped escape beat malformed");

  // Index returns to zero whenever an escape is released
  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_take_o |=> idx_q == '0)
    else $error("index not rewound after escape");

endmodule

// File: hdl/byte_escape_printer.sv
// Top level of the byte escape printer: encoder stage feeding a serializer.
// Depends on bep_pkg, bep_in_if, bep_out_if, bep_encoder and bep_serializer.
//
// Usage: each beat on in_i carries one raw byte and a new_string flag that
// restarts the space and required-length counters before that byte. Each beat
// on out_o carries one character result; the last beat caused by a byte has
// last_of_run set. A byte gives 1, 2 or 4 characters, or a single beat with
// char_valid low when its escape does not fit the remaining space.
// cfg_we_i/cfg_wdata_i write the output capacity (reset 512); it takes effect
// at the next new_string. Write it only while the block is idle.
// Flow: a byte is registered in the encoder as a rendered escape, then each of its
// characters is registered in the serializer's output register. Throughput: one
// character per cycle while the receiver does not stall; the serializer steps
// through the escape characters. The next byte is accepted while the last
// character of the current one moves to the output register.
// Reset: capacity and space left return to 512, required length to 1, both
// channels empty. When the receiver stalls, the output register holds its
// beat, and after one rendered escape is buffered in_i.ready drops.
module byte_escape_printer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bep_pkg::CapW-1:0]  cfg_wdata_i,
  bep_in_if.sink                    in_i,
  bep_out_if.source                 out_o
);

  bep_pkg::seq_t seq;
  logic          seq_valid;
  logic          seq_take;

  bep_encoder u_encoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .seq_o       (seq),
    .seq_valid_o (seq_valid),
    .seq_take_i  (seq_take)
  );

  bep_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_i       (seq),
    .seq_valid_i (seq_valid),
    .seq_take_o  (seq_take),
    .out_o       (out_o)
  );

endmodule
